[src/tmgc_pkg.sv]
// Shared types, constants and constant tables of the tone map and colormap core.
package tmgc_pkg;

  localparam int unsigned GammaDepth   = 1024;
  localparam int unsigned GammaIdxBits = $clog2(GammaDepth);
  localparam int unsigned FracBits     = 16;
  localparam int unsigned QuoBits      = 16;
  localparam int unsigned BigW         = 264;

  localparam logic OpMeasure = 1'b0;
  localparam logic OpMap     = 1'b1;

  typedef logic [15:0] gamma_tab_t [GammaDepth];

  // Largest y with (y/65536)^(11/5) <= k/D, found bit by bit on exact integers.
  function automatic logic [15:0] gamma_entry(input logic [31:0] k);
    logic [BigW-1:0] d5;
    logic [BigW-1:0] rhs;
    logic [BigW-1:0] lhs;
    logic [15:0]     y;
    logic [15:0]     cand;
    d5  = BigW'(1);
    rhs = '0;
    rhs[176] = 1'b1;
    for (int i = 0; i < 5; i++) begin
      d5  = d5 * BigW'(GammaDepth);
      rhs = rhs * BigW'(k);
    end
    y = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = y | (16'(1) << b);
      lhs  = d5;
      for (int i = 0; i < 11; i++) begin
        lhs = lhs * BigW'(cand);
      end
      if (lhs <= rhs) begin
        y = cand;
      end
    end
    return y;
  endfunction

  function automatic gamma_tab_t gamma_build();
    gamma_tab_t t;
    for (int k = 0; k < GammaDepth; k++) begin
      t[k] = gamma_entry(32'(k));
    end
    return t;
  endfunction

  localparam gamma_tab_t GammaTab = gamma_build();

  // Inferno segments, base and slope in hundredths, one row per segment (r, g, b).
  localparam logic signed [7:0] CmBase [4][3] = '{
    '{8'sd0,  8'sd0,  8'sd1},  '{8'sd34, 8'sd6,  8'sd27},
    '{8'sd58, 8'sd15, 8'sd43}, '{8'sd85, 8'sd33, 8'sd26}
  };
  localparam logic signed [7:0] CmSlope [4][3] = '{
    '{8'sd34, 8'sd6,  8'sd26},  '{8'sd24, 8'sd9,  8'sd16},
    '{8'sd27, 8'sd18, -8'sd17}, '{8'sd14, 8'sd37, -8'sd6}
  };

  typedef struct packed {
    logic peak_upd;
    logic div_load;
    logic div_step;
    logic rom_rd;
    logic cm_num;
    logic cm_scale;
    logic out_load;
  } tmgc_cmd_t;

endpackage

[src/tmgc_ctrl.sv]
// Controller state machine that sequences the divider, gamma ROM and colormap stages.
module tmgc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_opcode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmgc_pkg::tmgc_cmd_t cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDiv   = 3'd1;
  localparam logic [2:0] SRom   = 3'd2;
  localparam logic [2:0] SNum   = 3'd3;
  localparam logic [2:0] SScale = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       vld_q, vld_d;
  logic       acc;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = vld_q;
  assign acc         = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    vld_d   = vld_q & ~out_ready_i;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (acc) begin
          if (in_opcode_i == tmgc_pkg::OpMap) begin
            cmd_o.div_load = 1'b1;
            cnt_d          = '0;
            state_d        = SDiv;
          end else begin
            cmd_o.peak_upd = 1'b1;
          end
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 4'd1;
        if (cnt_q == 4'(tmgc_pkg::QuoBits - 1)) begin
          state_d = SRom;
        end
      end
      SRom: begin
        cmd_o.rom_rd = 1'b1;
        state_d      = SNum;
      end
      SNum: begin
        cmd_o.cm_num = 1'b1;
        state_d      = SScale;
      end
      SScale: begin
        cmd_o.cm_scale = 1'b1;
        state_d        = SOut;
      end
      SOut: begin
        if (!vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          vld_d          = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
    end
  end

endmodule

[src/tmgc_dpath.sv]
// Datapath: frame peak, restoring divider, gamma ROM and colormap arithmetic.
module tmgc_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmgc_pkg::tmgc_cmd_t cmd_i,
  input  logic [31:0]         intensity_i,
  input  logic                first_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o
);

  logic [31:0] peak_q;
  logic [32:0] rem_q;
  logic [32:0] dvs_q;
  logic [15:0] quo_q;
  logic [15:0] gam_q;
  logic [20:0] num_q [3];
  logic [12:0] x_q   [3];
  logic [7:0]  byte_q [3];

  logic [31:0] peak_eff;
  logic [33:0] r2;
  logic [1:0]  seg;
  logic [13:0] frac;
  logic signed [21:0] num_s [3];
  logic [28:0] prod255 [3];
  logic [25:0] prodrec [3];

  assign peak_eff = (peak_q == '0) ? (32'(1) << tmgc_pkg::FracBits) : peak_q;
  assign r2       = {rem_q, 1'b0};
  assign seg      = gam_q[15:14];
  assign frac     = gam_q[13:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_s[c]   = (22'(tmgc_pkg::CmBase[seg][c]) <<< 14)
                 + 22'(tmgc_pkg::CmSlope[seg][c]) * $signed({8'd0, frac});
      prod255[c] = 29'(num_q[c]) * 29'd255;
      // Divide by 25 through a reciprocal, exact for 13-bit operands.
      prodrec[c] = 26'(x_q[c]) * 26'd5243;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (cmd_i.peak_upd && (first_i || intensity_i > peak_q)) begin
      peak_q <= intensity_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= {1'b0, intensity_i};
      dvs_q <= 33'(intensity_i) + 33'(peak_eff);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (r2 >= {1'b0, dvs_q}) begin
        rem_q <= 33'(r2 - {1'b0, dvs_q});
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= r2[32:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (cmd_i.rom_rd) begin
      gam_q <= tmgc_pkg::GammaTab[quo_q[15 -: tmgc_pkg::GammaIdxBits]];
    end
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.cm_num) begin
        num_q[c] <= num_s[c][21] ? '0 : num_s[c][20:0];
      end
      if (cmd_i.cm_scale) begin
        x_q[c] <= prod255[c][28:16];
      end
      if (cmd_i.out_load) begin
        byte_q[c] <= (prodrec[c][25:17] > 9'd255) ? 8'd255 : prodrec[c][24:17];
      end
    end
  end

  assign red_o   = byte_q[0];
  assign green_o = byte_q[1];
  assign blue_o  = byte_q[2];

endmodule

[src/tone_map_gamma_colormap_core.sv]
// Top level of the tone map, gamma and colormap core.
//
//  Channel   Dir  Fields (lowest bit up)                        Word
//  s_axis    in   tdata: intensity[31:0]; tuser: opcode, first  one pixel
//  m_axis    out  tdata: red[7:0], green[15:8], blue[23:16]     one RGB pixel
//
// A measure word is absorbed in the cycle it is accepted and produces no output.
// A map word holds tready low after its acceptance while it passes through the
// one-bit-per-cycle restoring divider that forms I/(I+P), the gamma ROM read, and
// three colormap stages, the last loading the output register.
// No new word is therefore accepted until the map word has loaded the output register,
// and the RGB word is valid from that load until it is taken.
// Reset clears the frame peak, the sequencer and the output valid flag.
// A stalled output holds its word; a new word can be accepted while it waits, but a
// following map word then waits in the last stage until the output word is taken.
module tone_map_gamma_colormap_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // intensity[31:0]
  input  logic [1:0]  s_axis_tuser_i,   // opcode[0], first_of_frame[1]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // red[7:0], green[15:8], blue[23:16]
);

  tmgc_pkg::tmgc_cmd_t cmd;
  logic [7:0] red, green, blue;

  // The sequencer owns all timing; the datapath only follows its commands.
  tmgc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_opcode_i (s_axis_tuser_i[0]),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  tmgc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .intensity_i (s_axis_tdata_i),
    .first_i     (s_axis_tuser_i[1]),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  assign m_axis_tdata_o = {blue, green, red};

endmodule
